// ===== hw/rtl/bbce_pkg.sv =====
// Shared types and constants for the breakpoint curve evaluator.
// No dependencies; imported by every module of the block.
package bbce_pkg;

  localparam int unsigned DefMaxPoints = 64;
  localparam int unsigned TimeW  = 24;
  localparam int unsigned ValueW = 16;
  localparam int unsigned CfgW   = 7;

  // Operation decided by the front end for one queued item.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_EVAL,
    OP_SKIP
  } op_e;

  // One classified item as it sits in the queue.
  typedef struct packed {
    op_e               op;
    logic [5:0]        slot;
    logic [TimeW-1:0]  ptime;
    logic [ValueW-1:0] pvalue;
    logic [ValueW-1:0] pcurve;
    logic [TimeW-1:0]  position;
  } item_t;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_DIV,
    ST_CPM,
    ST_CPA,
    ST_CPD,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// ===== hw/rtl/bbce_front.sv =====
// Front end: accepts input items, classifies them and holds them in a
// two-entry queue. Depends on bbce_pkg.
module bbce_front
  import bbce_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [5:0]        point_slot_i,
  input  logic [TimeW-1:0]  point_time_i,
  input  logic [ValueW-1:0] point_value_i,
  input  logic [ValueW-1:0] point_curve_i,
  input  logic [TimeW-1:0]  position_i,
  output logic              q_valid_o,
  output item_t             q_item_o,
  input  logic              q_pop_i
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      item_in;

  // Classify: loads to a slot beyond the table are dropped.
  always_comb begin
    item_in.slot     = point_slot_i;
    item_in.ptime    = point_time_i;
    item_in.pvalue   = point_value_i;
    item_in.pcurve   = point_curve_i;
    item_in.position = position_i;
    if (kind_i) begin
      item_in.op = OP_EVAL;
    end else if (32'(point_slot_i) < MAX_POINTS) begin
      item_in.op = OP_LOAD;
    end else begin
      item_in.op = OP_SKIP;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== hw/rtl/bbce_back.sv =====
// Back end: breakpoint memory, segment search, serial divider, reciprocal
// multiply for the control value, shared multiplier and the output register.
// Depends on bbce_pkg.
module bbce_back
  import bbce_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] curve_value_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned EW = TimeW + 2 * ValueW;

  // Clamp a wide signed value to 0..1.0 in Q1.15.
  function automatic logic [ValueW-1:0] sat_unit(input logic signed [71:0] v);
    logic [ValueW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 72'sd32768) begin
      r = 16'd32768;
    end else begin
      r = v[ValueW-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [EW-1:0]     mem_q [MAX_POINTS];
  logic [EW-1:0]     rd_q;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       slot_w, n_w, nm1_w;
  logic [AW-1:0]     nm1;
  logic [CfgW-1:0]   cfg_q;

  logic [TimeW-1:0]  x_q;
  logic [EW-1:0]     prev_q;
  logic [AW-1:0]     j_q;
  logic [ValueW-1:0] vlast_q, v0_q, v1_q, cv_q;
  logic [TimeW-1:0]  d_q;
  logic [TimeW:0]    rem_q;
  logic [16:0]       s_q;
  logic [4:0]        cnt_q;
  logic [31:0]       dvd_q;
  logic [2:0]        step_q;
  logic              lin_q;
  logic signed [34:0] m1_q;
  logic signed [50:0] pa_q, pb_q, pc_q;
  logic signed [71:0] acc_q;
  logic [ValueW-1:0] res_q;
  logic              out_valid_q;
  logic [ValueW-1:0] out_data_q;

  logic [TimeW-1:0]  cur_t, prev_t, diff, dseg;
  logic [ValueW-1:0] cur_v;
  logic              found, out_free;
  logic signed [16:0] dv;
  logic [16:0]       adv;
  logic signed [17:0] u_s, s_s;
  logic signed [32:0] cp8;
  logic signed [50:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [68:0] prod;
  logic [TimeW:0]    r2;
  logic              ge;
  logic [63:0]       recip;
  logic [16:0]       vsum;
  logic [31:0]       vterm;
  logic signed [39:0] num, biased;

  // Table size in use and write address.
  assign slot_w = 32'(q_item_i.slot);
  assign n_w    = (32'(cfg_q) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(cfg_q);
  assign nm1_w  = n_w - 32'd1;
  assign nm1    = nm1_w[AW-1:0];

  // Segment search and arithmetic helpers.
  assign cur_t    = rd_q[EW-1 -: TimeW];
  assign cur_v    = rd_q[2*ValueW-1 -: ValueW];
  assign prev_t   = prev_q[EW-1 -: TimeW];
  assign diff     = x_q - prev_t;
  assign dseg     = cur_t - prev_t;
  assign found    = (j_q != '0) && (x_q >= prev_t) && (x_q <= cur_t);
  assign out_free = !out_valid_q || out_ready_i;
  assign dv       = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
  assign adv      = (dv < 0) ? 17'(-dv) : 17'(dv);
  assign s_s      = $signed({1'b0, s_q});
  assign u_s      = $signed(18'(18'd65536 - {1'b0, s_q}));
  assign cp8      = $signed({1'b0, dvd_q}) - 33'sh20000000;
  assign r2       = {rem_q[TimeW-1:0], 1'b0};
  assign ge       = r2 >= {1'b0, d_q};
  // Divide by five as a 32 by 32 product with the reciprocal, exact for 32 bits.
  assign recip    = {32'd0, dvd_q} * {32'd0, 32'hCCCCCCCD};
  assign vsum     = {1'b0, v0_q} + {1'b0, v1_q};
  assign vterm    = 32'(vsum) * 32'd20480;
  assign num      = $signed({8'd0, vterm}) + 40'(m1_q) * 40'sd6 + 40'sd80;
  assign biased   = (num >>> 5) + 40'sd2684354560;
  assign prod     = mul_a * mul_b;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 51'($signed(cv_q));
    mul_b = $signed({1'b0, adv});
    if (state_q == ST_MUL) begin
      case (step_q)
        3'd0: begin
          if (lin_q) begin
            mul_a = 51'(dv);
            mul_b = s_s;
          end else begin
            mul_a = 51'($signed({1'b0, v0_q}));
            mul_b = u_s;
          end
        end
        3'd1: begin
          mul_a = 51'($signed({1'b0, v1_q}));
          mul_b = s_s;
        end
        3'd2: begin
          mul_a = 51'(cp8);
          mul_b = s_s;
        end
        3'd3: begin
          mul_a = pa_q;
          mul_b = u_s;
        end
        3'd4: begin
          mul_a = pb_q;
          mul_b = s_s;
        end
        default: begin
          mul_a = pc_q;
          mul_b = u_s;
        end
      endcase
    end
  end

  // Next state, queue pop and memory read address.
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == OP_EVAL) begin
            state_d = (n_w == 32'd0) ? ST_OUT : ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        rd_addr = nm1;
        state_d = (x_q <= cur_t) ? ST_OUT : ST_LAST;
      end
      ST_LAST: begin
        state_d = (x_q >= cur_t) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        rd_addr = j_q + 1'b1;
        if (found) begin
          if (dseg != '0) begin
            state_d = ST_DIV;
          end else begin
            state_d = (prev_q[ValueW-1:0] == '0) ? ST_MUL : ST_CPM;
          end
        end else if (j_q == nm1) begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = lin_q ? ST_MUL : ST_CPM;
        end
      end
      ST_CPM: state_d = ST_CPA;
      ST_CPA: state_d = ST_CPD;
      ST_CPD: state_d = ST_MUL;
      ST_MUL: begin
        if (lin_q || step_q == 3'd5) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Breakpoint memory with registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i && q_item_i.op == OP_LOAD) begin
      mem_q[slot_w[AW-1:0]] <= {q_item_i.ptime, q_item_i.pvalue, q_item_i.pcurve};
    end
    rd_q <= mem_q[rd_addr];
  end

  // Evaluation datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q   <= q_item_i.position;
        res_q <= '0;
      end
      ST_FIRST: res_q <= sat_unit(72'(cur_v));
      ST_LAST: begin
        vlast_q <= cur_v;
        res_q   <= sat_unit(72'(cur_v));
        j_q     <= '0;
      end
      ST_SCAN: begin
        prev_q <= rd_q;
        j_q    <= j_q + 1'b1;
        if (found) begin
          v0_q  <= prev_q[2*ValueW-1 -: ValueW];
          cv_q  <= prev_q[ValueW-1:0];
          lin_q <= (prev_q[ValueW-1:0] == '0);
          v1_q  <= cur_v;
          d_q   <= dseg;
          cnt_q <= 5'd15;
          step_q <= 3'd0;
          if (dseg == '0) begin
            s_q <= '0;
          end else if (diff >= dseg) begin
            s_q   <= 17'h10000;
            rem_q <= {1'b0, diff - dseg};
          end else begin
            s_q   <= '0;
            rem_q <= {1'b0, diff};
          end
        end
      end
      ST_DIV: begin
        rem_q <= ge ? (r2 - {1'b0, d_q}) : r2;
        s_q   <= {s_q[16], s_q[14:0], ge};
        cnt_q <= cnt_q - 5'd1;
      end
      ST_CPM: m1_q <= prod[34:0];
      ST_CPA: dvd_q <= biased[31:0];
      ST_CPD: begin
        dvd_q  <= 32'(recip[63:34]);
        step_q <= 3'd0;
      end
      ST_MUL: begin
        step_q <= step_q + 3'd1;
        case (step_q)
          3'd0: pa_q <= prod[50:0];
          3'd1: pb_q <= prod[50:0];
          3'd2: pc_q <= prod[50:0];
          3'd3: acc_q <= 72'(prod) <<< 8;
          3'd4: acc_q <= acc_q + (72'(prod) <<< 8);
          default: acc_q <= acc_q + (72'(prod) <<< 1);
        endcase
      end
      ST_FIN: begin
        if (lin_q) begin
          res_q <= sat_unit(72'($signed({1'b0, v0_q}))
                            + ((72'(pa_q) + 72'sd32768) >>> 16));
        end else begin
          res_q <= sat_unit((acc_q + 72'sh8000000000) >>> 40);
        end
      end
      default: begin
      end
    endcase
    if (state_q == ST_SCAN && !found) begin
      res_q <= sat_unit(72'(vlast_q));
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= res_q;
    end
  end

  // Control registers: state, count register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_value_o = out_data_q;

endmodule

// ===== hw/rtl/bezier_breakpoint_curve_eval.sv =====
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  kind, point_slot, point_time, point_value,
//                                   point_curve, position
// out      out_valid_o / out_ready_i curve_value
// cfg      cfg_we_i                 cfg_wdata_i (points_in_use)
// An evaluate item with no points in use goes straight to the output; one at
// or before the first time or at or past the last takes that point's value;
// otherwise the scan reads the table, one memory read per cycle, until it
// finds the segment, 16 division steps follow for a segment of nonzero length,
// then one multiply for a linear segment or, for a curved one, a control-point
// product, a reciprocal multiply by one fifth and six passes of the shared
// multiplier. Reset empties the queue and the output register and sets the
// count to zero; the table holds nothing until loaded. A stalled output holds
// one result while the two-entry queue keeps accepting items until it is full.
module bezier_breakpoint_curve_eval
  import bbce_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [5:0]        point_slot_i,
  input  logic [TimeW-1:0]  point_time_i,
  input  logic [ValueW-1:0] point_value_i,
  input  logic [ValueW-1:0] point_curve_i,
  input  logic [TimeW-1:0]  position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] curve_value_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  // Item intake and queue.
  bbce_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .point_slot_i,
    .point_time_i, .point_value_i, .point_curve_i, .position_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // Table, search and arithmetic.
  bbce_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .curve_value_o
  );

`ifndef ASSERT_OFF
  // Every delivered result lies in 0..1.0.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> curve_value_o <= 16'd32768)
    else $error("result above unit range");

  // The back end never takes from an empty queue.
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A full queue always presents a head item.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full without head item");
`endif

endmodule
